FILE: hw/rtl/sync_length_frame_catcher_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync length frame catcher
// Shared macro forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_CATCHER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_FRAME_CATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SLFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/slfc_pkg.sv
// ----------------------------------------------------------------------------
// slfc_pkg
// Types, constants and the opcode table of the sync length frame catcher.
// ----------------------------------------------------------------------------
package slfc_pkg;

  localparam int BufDepth  = 512;
  localparam int BufAddrW  = $clog2(BufDepth);
  localparam int ByteW     = 8;
  localparam int IndexW    = 9;
  localparam int FuncW     = 2;
  localparam int LenExtra  = 7;
  localparam int FrameMax  = (1 << ByteW) - 1 + LenExtra;
  localparam int FrameW    = $clog2(FrameMax + 1);
  localparam int InDataW   = 24;
  localparam int OutDataW  = 24;

  localparam logic [ByteW-1:0] SyncByte = 8'hFF;

  localparam logic [FuncW-1:0] FuncByte    = 2'd0;
  localparam logic [FuncW-1:0] FuncRead    = 2'd1;
  localparam logic [FuncW-1:0] FuncRelease = 2'd2;

  typedef struct packed {
    logic              frame_ready;
    logic [FrameW-1:0] frame_length;
    logic              byte_stored;
  } slfc_status_t;

  typedef struct packed {
    logic                en;
    logic [BufAddrW-1:0] addr;
    logic [ByteW-1:0]    data;
  } slfc_wr_t;

  function automatic logic opcode_ok(input logic [ByteW-1:0] op);
    return op inside {[8'h01:8'h0F], [8'h21:8'h2A], [8'h2D:8'h2F], [8'h61:8'h6D],
                      [8'h70:8'h72], [8'h91:8'h9E], 8'hC1, 8'hC3};
  endfunction

endpackage

FILE: hw/rtl/slfc_ram.sv
// ----------------------------------------------------------------------------
// slfc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module slfc_ram #(
  parameter int Depth = 512,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/slfc_ctrl.sv
// ----------------------------------------------------------------------------
// slfc_ctrl
// Frame hunt state: fill count, length and opcode shadows, held frame.
// ----------------------------------------------------------------------------
module slfc_ctrl import slfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [FuncW-1:0] func,
  input  logic [ByteW-1:0] rx_byte,
  output slfc_status_t     stat,
  output slfc_wr_t         wr
);

  logic [FrameW-1:0] fill_count, fill_count_next;
  logic [FrameW-1:0] held_length, held_length_next;
  logic              frame_held, frame_held_next;
  logic [ByteW-1:0]  len_byte, len_byte_next;
  logic [ByteW-1:0]  op_byte, op_byte_next;

  logic [FrameW-1:0] fill_inc;
  logic [FrameW-1:0] total;
  logic [ByteW-1:0]  len_sel;
  logic [ByteW-1:0]  op_sel;
  logic              stored;

  // Length and opcode bytes bypass their shadows on the cycle they arrive.
  assign len_sel  = (fill_count == FrameW'(1)) ? rx_byte : len_byte;
  assign op_sel   = (fill_count == FrameW'(2)) ? rx_byte : op_byte;
  assign total    = FrameW'(len_sel) + FrameW'(LenExtra);
  assign fill_inc = fill_count + FrameW'(1);

  always_comb begin
    fill_count_next  = fill_count;
    held_length_next = held_length;
    frame_held_next  = frame_held;
    len_byte_next    = len_byte;
    op_byte_next     = op_byte;
    stored           = 1'b0;
    if (step) begin
      case (func)
        FuncByte: begin
          if (!frame_held && !(fill_count == '0 && rx_byte != SyncByte)) begin
            stored          = 1'b1;
            fill_count_next = fill_inc;
            if (fill_count == FrameW'(1)) len_byte_next = rx_byte;
            if (fill_count == FrameW'(2)) op_byte_next = rx_byte;
            if (fill_inc >= FrameW'(2) && fill_inc == total) begin
              if (opcode_ok(op_sel)) begin
                frame_held_next  = 1'b1;
                held_length_next = total;
              end else begin
                fill_count_next = '0;
              end
            end
          end
        end
        FuncRelease: begin
          if (frame_held) begin
            frame_held_next  = 1'b0;
            held_length_next = '0;
            fill_count_next  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      held_length <= '0;
      frame_held  <= 1'b0;
    end else begin
      fill_count  <= fill_count_next;
      held_length <= held_length_next;
      frame_held  <= frame_held_next;
    end
  end

  always_ff @(posedge clk) begin
    len_byte <= len_byte_next;
    op_byte  <= op_byte_next;
  end

  assign stat.frame_ready  = frame_held_next;
  assign stat.frame_length = held_length_next;
  assign stat.byte_stored  = stored;

  assign wr.en   = stored;
  assign wr.addr = BufAddrW'(fill_count);
  assign wr.data = rx_byte;

endmodule

FILE: hw/rtl/slfc_outq.sv
// ----------------------------------------------------------------------------
// slfc_outq
// Result path: read-latency stage followed by the output word register.
// ----------------------------------------------------------------------------
module slfc_outq import slfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  slfc_status_t        push_stat,
  input  logic                push_rd,
  input  logic [ByteW-1:0]    ram_q,
  output logic                can_push,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata
);

  logic         s1_valid;
  slfc_status_t s1_stat;
  logic         s1_rd;
  logic         s1_move;
  logic [ByteW-1:0] rd_byte;

  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign can_push = !s1_valid || s1_move;
  assign rd_byte  = s1_rd ? ram_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (can_push) s1_valid <= push;
      if (s1_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && can_push) begin
      s1_stat <= push_stat;
      s1_rd   <= push_rd;
    end
    // pack: ready, length, read byte, stored flag; zero pad on top
    if (s1_move) begin
      m_tdata <= {(OutDataW - 2 - FrameW - ByteW)'(0), s1_stat.byte_stored, rd_byte,
                  s1_stat.frame_length, s1_stat.frame_ready};
    end
  end

endmodule

FILE: hw/rtl/sync_length_frame_catcher_unit.sv
// ----------------------------------------------------------------------------
// sync_length_frame_catcher_unit
// Sync-byte, length-prefixed frame deframer with a byte buffer in RAM.
// ----------------------------------------------------------------------------
//  port group  dir  word contents
//  s_*         in   tuser[1:0] func; tdata rx_byte[7:0], read_index[16:8]
//  m_*         out  tdata ready[0], length[9:1], read_data[17:10], stored[18]
//
//  One word in per cycle while s_tready is high, one result word out per input word.
//  Results pass the RAM read stage, then the output register.
//  Frame state updates in the accept cycle, so a read right after a write
//  sees the new byte through the RAM port ordering.
//  rst clears hunt state and the pipeline; buffer contents stay undefined.
//  A stall on m_tready fills both stages, then drops s_tready.
// ----------------------------------------------------------------------------
module sync_length_frame_catcher_unit import slfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // rx_byte[7:0], read_index[16:8]
  input  logic [FuncW-1:0]    s_tuser,   // func[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata    // ready, length[9:1], read_data, stored
);

  logic              accept;
  logic [ByteW-1:0]  rx_byte;
  logic [IndexW-1:0] read_index;
  logic              rd_en;
  logic              rd_in_range;
  logic [ByteW-1:0]  ram_q;
  slfc_status_t      stat;
  slfc_wr_t          wr;

  assign accept      = s_tvalid && s_tready;
  assign rx_byte     = s_tdata[ByteW-1:0];
  assign read_index  = s_tdata[ByteW +: IndexW];
  assign rd_in_range = int'(read_index) < BufDepth;
  assign rd_en       = accept && (s_tuser == FuncRead) && rd_in_range;

  slfc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .func    (s_tuser),
    .rx_byte (rx_byte),
    .stat    (stat),
    .wr      (wr)
  );

  slfc_ram #(
    .Depth (BufDepth),
    .Width (ByteW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (BufAddrW'(read_index)),
    .rd_data (ram_q)
  );

  slfc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_stat (stat),
    .push_rd   (rd_en),
    .ram_q     (ram_q),
    .can_push  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: hw/rtl/slfc_checker.sv
// ----------------------------------------------------------------------------
// slfc_checker
// Port-level checks on the result stream of the frame catcher.
// ----------------------------------------------------------------------------
`include "sync_length_frame_catcher_unit_defines.svh"

module slfc_checker import slfc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  `SLFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

  `SLFC_ASSERT_NOW(a_len_ready, m_tvalid, m_tdata[0] == (m_tdata[9:1] != '0), "frame length disagrees with ready flag")

  `SLFC_ASSERT_NOW(a_len_min, m_tvalid && m_tdata[0], m_tdata[9:1] >= 9'd7, "held frame shorter than header")

  `SLFC_ASSERT_NOW(a_store_no_read, m_tvalid && m_tdata[18], m_tdata[17:10] == '0, "stored byte word carries read data")

endmodule

bind sync_length_frame_catcher_unit slfc_checker u_slfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
